// ===== hdl/bcdcal_pkg.sv =====
// shared types and constants for the bcd calendar clock register file
package bcdcal_pkg;

   // operation codes carried by req_cmd
   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } cmd_type;

   // clock byte count and register numbers
   localparam int unsigned CLOCK_COUNT = 10;
   localparam logic [3:0] REG_SEC  = 4'd0;
   localparam logic [3:0] REG_MIN  = 4'd2;
   localparam logic [3:0] REG_HOUR = 4'd4;
   localparam logic [3:0] REG_DOW  = 4'd6;
   localparam logic [3:0] REG_DOM  = 4'd7;
   localparam logic [3:0] REG_MON  = 4'd8;
   localparam logic [3:0] REG_YEAR = 4'd9;
   localparam logic [3:0] REG_A    = 4'd10;
   localparam logic [3:0] REG_B    = 4'd11;
   localparam logic [3:0] REG_C    = 4'd12;

   // register b and c bit masks
   localparam logic [7:0] B_DATA_MODE = 8'h04;
   localparam logic [7:0] C_UPDATE    = 8'h10;
   localparam logic [7:0] C_CAPS      = 8'h02;
   localparam logic [7:0] C_STORE     = 8'h80;
   localparam logic [7:0] C_NUM       = 8'h01;
   localparam logic [7:0] C_SD        = 8'h0C;

   // reset value of the register b fixed bits
   localparam logic [7:0] B_FIXED_RESET = 8'h02;

   // the CLOCK_COUNT clock bytes held in binary
   typedef logic [CLOCK_COUNT-1:0][7:0] clock_array_type;

endpackage

// ===== hdl/bcdcal_tick.sv =====
// one-second advance of the binary clock and calendar bytes
module bcdcal_tick (
   input  bcdcal_pkg::clock_array_type cur_bytes,
   output bcdcal_pkg::clock_array_type next_bytes
);
   import bcdcal_pkg::*;

   localparam logic [7:0] MONTH_DAYS [12] = '{
      8'd31, 8'd28, 8'd31, 8'd30, 8'd31, 8'd30,
      8'd31, 8'd31, 8'd30, 8'd31, 8'd30, 8'd31
   };

   logic [7:0] sec_inc;
   logic [7:0] min_inc;
   logic [7:0] hour_inc;
   logic [7:0] dow_inc;
   logic [7:0] dom_inc;
   logic [7:0] mon_inc;
   logic [7:0] year_inc;
   logic [7:0] mon_zero;
   logic [7:0] base_days;
   logic [7:0] month_len;
   logic       sec_carry;
   logic       min_carry;
   logic       hour_carry;
   logic       dom_carry;
   logic       mon_carry;

   // wrapping increments of each field
   assign sec_inc  = cur_bytes[REG_SEC] + 8'd1;
   assign min_inc  = cur_bytes[REG_MIN] + 8'd1;
   assign hour_inc = cur_bytes[REG_HOUR] + 8'd1;
   assign dow_inc  = cur_bytes[REG_DOW] + 8'd1;
   assign dom_inc  = cur_bytes[REG_DOM] + 8'd1;
   assign mon_inc  = cur_bytes[REG_MON] + 8'd1;
   assign year_inc = cur_bytes[REG_YEAR] + 8'd1;

   // length of the current month, leap february when year is a multiple of four
   assign mon_zero  = cur_bytes[REG_MON] - 8'd1;
   assign base_days = (mon_zero > 8'd11) ? 8'd31 : MONTH_DAYS[mon_zero[3:0]];
   assign month_len = (base_days == 8'd28 && cur_bytes[REG_YEAR][1:0] == 2'b00) ?
                      8'd29 : base_days;

   // carry chain
   assign sec_carry  = sec_inc >= 8'd60;
   assign min_carry  = sec_carry && min_inc >= 8'd60;
   assign hour_carry = min_carry && hour_inc >= 8'd24;
   assign dom_carry  = hour_carry && dom_inc > month_len;
   assign mon_carry  = dom_carry && mon_inc > 8'd12;

   // next byte values
   always_comb begin
      next_bytes = cur_bytes;
      next_bytes[REG_SEC] = sec_carry ? 8'd0 : sec_inc;
      if (sec_carry) begin
         next_bytes[REG_MIN] = min_carry ? 8'd0 : min_inc;
      end
      if (min_carry) begin
         next_bytes[REG_HOUR] = hour_carry ? 8'd0 : hour_inc;
      end
      if (hour_carry) begin
         next_bytes[REG_DOW] = (dow_inc > 8'd7) ? 8'd1 : dow_inc;
         next_bytes[REG_DOM] = dom_carry ? 8'd1 : dom_inc;
      end
      if (dom_carry) begin
         next_bytes[REG_MON] = mon_carry ? 8'd1 : mon_inc;
      end
      if (mon_carry) begin
         next_bytes[REG_YEAR] = (year_inc >= 8'd100) ? 8'd0 : year_inc;
      end
   end

endmodule

// ===== hdl/bcd_calendar_clock_registers.sv =====
// top level of the bcd calendar clock register file
// Register file of thirteen byte registers in the manner of a classic clock chip: seconds,
// minutes, hours, day of week, day of month, month and year (0 to 9, kept in binary and shown
// in bcd unless bit 2 of register b is set), storage page a, mode b and status c. Each request
// is a one-second tick, a read or a write. A request goes into an input register and is
// carried out from there in one pass of short logic; a read leaves its byte in the
// output register. One request per clock is taken as long as rsp_stall does not hold a
// pending read. The csr port loads the bits that are ORed into register b on its next write;
// it is always ready.
module bcd_calendar_clock_registers (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [3:0] req_reg_index,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);
   import bcdcal_pkg::*;

   // clock bytes after reset: year 0, month, day of month and day of week 1, rest 0
   localparam clock_array_type CLOCK_RESET = {8'd0, 8'd1, 8'd1, 8'd1, 48'd0};

   logic            in_valid_ff;
   cmd_type         cmd_ff;
   logic [3:0]      idx_ff;
   logic [7:0]      data_ff;
   logic [7:0]      fixed_ff;
   clock_array_type clock_ff;
   clock_array_type clock_in;
   clock_array_type tick_bytes;
   logic [7:0]      page_ff;
   logic [7:0]      page_in;
   logic [7:0]      mode_ff;
   logic [7:0]      mode_in;
   logic [7:0]      status_ff;
   logic [7:0]      status_in;
   logic            rsp_valid_ff;
   logic [7:0]      rsp_data_ff;
   logic            exec;
   logic            is_read;
   logic            bcd_mode;
   logic [7:0]      read_value;
   logic [7:0]      clock_raw;
   logic [7:0]      write_bin;

   // binary to bcd, quotient by reciprocal multiply (exact for 8-bit values)
   function automatic logic [7:0] to_bcd(input logic [7:0] v);
      logic [15:0] prod;
      logic [4:0]  quo;
      logic [7:0]  rem;
      logic [7:0]  quo_ten;
      prod    = v * 16'd205;
      quo     = prod[15:11];
      quo_ten = {3'b000, quo} * 8'd10;
      rem     = v - quo_ten;
      to_bcd  = {quo[3:0], 4'b0000} + rem;
   endfunction

   // bcd to binary, nibbles taken as is
   function automatic logic [7:0] from_bcd(input logic [7:0] v);
      logic [7:0] hi;
      hi       = {4'b0000, v[7:4]};
      from_bcd = (hi << 3) + (hi << 1) + {4'b0000, v[3:0]};
   endfunction

   // handshake control
   assign is_read   = cmd_ff == CMD_READ;
   assign exec      = in_valid_ff && !(is_read && rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && !exec;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

   // tick arithmetic
   bcdcal_tick u_tick (
      .cur_bytes  (clock_ff),
      .next_bytes (tick_bytes)
   );

   assign bcd_mode  = (mode_ff & B_DATA_MODE) == 8'h00;
   assign write_bin = bcd_mode ? from_bcd(data_ff) : data_ff;

   // read mux
   always_comb begin
      clock_raw  = 8'h00;
      read_value = 8'h00;
      if (idx_ff < REG_A) begin
         clock_raw  = clock_ff[idx_ff];
         read_value = bcd_mode ? to_bcd(clock_raw) : clock_raw;
      end else if (idx_ff == REG_A) begin
         read_value = page_ff;
      end else if (idx_ff == REG_B) begin
         read_value = mode_ff;
      end else if (idx_ff == REG_C) begin
         read_value = status_ff & ~(C_NUM | C_SD);
      end
   end

   // next register file state
   always_comb begin
      clock_in  = clock_ff;
      page_in   = page_ff;
      mode_in   = mode_ff;
      status_in = status_ff;
      if (exec) begin
         case (cmd_ff)
            CMD_TICK: begin
               clock_in  = tick_bytes;
               status_in = status_ff | C_UPDATE;
            end
            CMD_READ: begin
               if (idx_ff == REG_C) begin
                  status_in = status_ff & ~C_UPDATE;
               end
            end
            CMD_WRITE: begin
               if (idx_ff < REG_A) begin
                  clock_in[idx_ff] = write_bin;
               end else if (idx_ff == REG_A) begin
                  page_in = data_ff;
               end else if (idx_ff == REG_B) begin
                  mode_in = (data_ff & B_DATA_MODE) | fixed_ff;
               end else if (idx_ff == REG_C) begin
                  status_in = (status_ff & ~(C_CAPS | C_STORE)) |
                              (data_ff & (C_CAPS | C_STORE));
               end
            end
            default: begin
            end
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (exec) begin
         in_valid_ff <= 1'b0;
      end
      if (req_valid && !req_stall) begin
         cmd_ff  <= cmd_type'(req_cmd);
         idx_ff  <= req_reg_index;
         data_ff <= req_write_data;
      end
   end

   // register file and csr
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff          <= CLOCK_RESET;
         page_ff           <= 8'h00;
         mode_ff           <= B_FIXED_RESET;
         status_ff         <= 8'h00;
         fixed_ff          <= B_FIXED_RESET;
      end else begin
         clock_ff  <= clock_in;
         page_ff   <= page_in;
         mode_ff   <= mode_in;
         status_ff <= status_in;
         if (csr_valid && csr_ready) begin
            fixed_ff <= csr_data;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (exec && is_read) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (exec && is_read) begin
         rsp_data_ff <= read_value;
      end
   end

   // an executed read always leaves a result behind
   assert property (@(posedge clock) disable iff (reset)
      exec && is_read |=> rsp_valid_ff)
      else $error("read executed without a result");

   // a tick leaves the update flag set
   assert property (@(posedge clock) disable iff (reset)
      exec && cmd_ff == CMD_TICK |=> (status_ff & C_UPDATE) != 8'h00)
      else $error("update flag not set after tick");

   // a pending result that is not taken is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending result lost");

   // input is only held back behind a pending read
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && is_read && rsp_valid_ff)
      else $error("input stalled without cause");

endmodule

// ===== test/bcd_calendar_clock_checker.sv =====
// checker for the bcd calendar clock register file: predicts read data and compares transfers
module bcd_calendar_clock_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [1:0] req_cmd,
   input  logic [3:0] req_reg_index,
   input  logic [7:0] req_write_data,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_read_data,
   input  logic       csr_valid,
   input  logic       csr_ready,
   input  logic [7:0] csr_data,
   output int         fail_count,
   output int         reads_waiting
);
   import bcdcal_pkg::*;

   // shadow copy of the register file and the csr value
   logic [7:0] fixed_bits;
   logic [7:0] clock_bytes [CLOCK_COUNT];
   logic [7:0] storage_page;
   logic [7:0] mode_byte;
   logic [7:0] status_byte;

   // read data still owed by the block, oldest first
   logic [7:0] owed_read_bytes [$];

   initial fail_count = 0;
   initial reads_waiting = 0;

   function automatic logic [7:0] to_bcd_byte(input logic [7:0] v);
      logic [7:0] tens;
      tens = v / 8'd10;
      // tens above 15 drop out of the byte
      return {tens[3:0], 4'b0000} + (v % 8'd10);
   endfunction

   function automatic logic [7:0] from_bcd_byte(input logic [7:0] v);
      logic [7:0] r;
      r = v[7:4] * 8'd10 + v[3:0];
      return r;
   endfunction

   // days in the current month, out-of-range months count as 31
   function automatic logic [7:0] month_length();
      logic [7:0] m;
      logic [7:0] d;
      m = clock_bytes[REG_MON] - 8'd1;
      case (m)
         8'd1: d = 8'd28;
         8'd3, 8'd5, 8'd8, 8'd10: d = 8'd30;
         default: d = 8'd31;
      endcase
      if (d == 8'd28 && clock_bytes[REG_YEAR][1:0] == 2'b00) d = 8'd29;
      return d;
   endfunction

   // one-second tick with 8-bit wrapping bumps
   function automatic void advance_second();
      clock_bytes[REG_SEC] = clock_bytes[REG_SEC] + 8'd1;
      if (clock_bytes[REG_SEC] >= 8'd60) begin
         clock_bytes[REG_SEC] = 8'd0;
         clock_bytes[REG_MIN] = clock_bytes[REG_MIN] + 8'd1;
         if (clock_bytes[REG_MIN] >= 8'd60) begin
            clock_bytes[REG_MIN] = 8'd0;
            clock_bytes[REG_HOUR] = clock_bytes[REG_HOUR] + 8'd1;
            if (clock_bytes[REG_HOUR] >= 8'd24) begin
               clock_bytes[REG_HOUR] = 8'd0;
               clock_bytes[REG_DOW] = clock_bytes[REG_DOW] + 8'd1;
               if (clock_bytes[REG_DOW] > 8'd7) clock_bytes[REG_DOW] = 8'd1;
               clock_bytes[REG_DOM] = clock_bytes[REG_DOM] + 8'd1;
               if (clock_bytes[REG_DOM] > month_length()) begin
                  clock_bytes[REG_DOM] = 8'd1;
                  clock_bytes[REG_MON] = clock_bytes[REG_MON] + 8'd1;
                  if (clock_bytes[REG_MON] > 8'd12) begin
                     clock_bytes[REG_MON] = 8'd1;
                     clock_bytes[REG_YEAR] = clock_bytes[REG_YEAR] + 8'd1;
                     if (clock_bytes[REG_YEAR] >= 8'd100) clock_bytes[REG_YEAR] = 8'd0;
                  end
               end
            end
         end
      end
      status_byte = status_byte | C_UPDATE;
   endfunction

   // register read, reading c clears the update flag
   function automatic logic [7:0] read_register(input logic [3:0] idx);
      logic [7:0] v;
      v = 8'd0;
      if (idx < CLOCK_COUNT) begin
         v = clock_bytes[idx];
         if ((mode_byte & B_DATA_MODE) == 8'd0) v = to_bcd_byte(v);
      end else if (idx == REG_A) begin
         v = storage_page;
      end else if (idx == REG_B) begin
         v = mode_byte;
      end else if (idx == REG_C) begin
         v = status_byte & ~(C_NUM | C_SD);
         status_byte = status_byte & ~C_UPDATE;
      end
      return v;
   endfunction

   // register write, clock bytes stored unchecked
   function automatic void write_register(input logic [3:0] idx, input logic [7:0] data);
      if (idx < CLOCK_COUNT) begin
         if ((mode_byte & B_DATA_MODE) == 8'd0) data = from_bcd_byte(data);
         clock_bytes[idx] = data;
      end else if (idx == REG_A) begin
         storage_page = data;
      end else if (idx == REG_B) begin
         mode_byte = (data & B_DATA_MODE) | fixed_bits;
      end else if (idx == REG_C) begin
         status_byte = (status_byte & ~(C_CAPS | C_STORE)) | (data & (C_CAPS | C_STORE));
      end
   endfunction

   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         fixed_bits = B_FIXED_RESET;
         foreach (clock_bytes[i]) clock_bytes[i] = 8'd0;
         clock_bytes[REG_DOW] = 8'd1;
         clock_bytes[REG_DOM] = 8'd1;
         clock_bytes[REG_MON] = 8'd1;
         storage_page = 8'd0;
         mode_byte = B_FIXED_RESET;
         status_byte = 8'd0;
         owed_read_bytes.delete();
      end else begin
         // result transfer against the oldest owed byte
         if (rsp_valid && !rsp_stall) begin
            if (owed_read_bytes.size() == 0) begin
               if (fail_count < 50)
                  $display("%0t: read data 0x%02h with no read outstanding",
                           $time, rsp_read_data);
               fail_count++;
            end else begin
               want = owed_read_bytes.pop_front();
               if (rsp_read_data !== want) begin
                  if (fail_count < 50)
                     $display("%0t: read data expected 0x%02h actual 0x%02h",
                              $time, want, rsp_read_data);
                  fail_count++;
               end
            end
         end
         // csr write only takes effect at the next write to b
         if (csr_valid && csr_ready) fixed_bits = csr_data;
         // request transfer
         if (req_valid && !req_stall) begin
            case (req_cmd)
               CMD_TICK: advance_second();
               CMD_READ: owed_read_bytes.push_back(read_register(req_reg_index));
               CMD_WRITE: write_register(req_reg_index, req_write_data);
               default: ;
            endcase
         end
      end
      reads_waiting <= owed_read_bytes.size();
   end

endmodule

// ===== test/bcd_calendar_clock_registers_test.sv =====
// stimulus, clocking and verdict for the bcd calendar clock register file
module bcd_calendar_clock_registers_test;
   import bcdcal_pkg::*;

   // codes the package leaves unnamed
   localparam logic [1:0] CMD_UNUSED     = 2'd3;
   localparam logic [3:0] REG_SEC_ALARM  = 4'd1;
   localparam logic [3:0] REG_MIN_ALARM  = 4'd3;
   localparam logic [3:0] REG_HOUR_ALARM = 4'd5;
   localparam logic [3:0] REG_D          = 4'd13;
   localparam logic [3:0] REG_E          = 4'd14;
   localparam logic [3:0] REG_NVRAM      = 4'd15;

   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 4;
   localparam int PHASE_ITEMS   = 265;
   localparam int CYCLE_LIMIT   = 100000;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_cmd;
   logic [3:0] req_reg_index;
   logic [7:0] req_write_data;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_read_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_data;
   int         fail_count;
   int         reads_waiting;

   // stimulus bookkeeping
   int   item_count = 0;
   int   tick_count = 0;
   int   read_count = 0;
   int   write_count = 0;
   int   setting_count = 0;
   int   cycle_count = 0;
   logic sender_idles = 1'b1;
   logic receiver_idles = 1'b1;
   logic hold_off = 1'b0;
   logic binary_mode = 1'b0;
   logic [7:0] fixed_now = B_FIXED_RESET;

   bcd_calendar_clock_registers dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   bcd_calendar_clock_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .fail_count     (fail_count),
      .reads_waiting  (reads_waiting)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // receiver: random stalls and one long hold-off counted here
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_off = 1'b0;
         end else begin
            rsp_stall <= receiver_idles && ($urandom_range(99) < 7);
         end
      end
   end

   // one request transfer, with an occasional gap ahead of it
   task automatic offer(input logic [1:0] cmd, input logic [3:0] idx, input logic [7:0] data);
      if (sender_idles && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_reg_index  <= idx;
      req_write_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      item_count++;
      case (cmd)
         CMD_TICK: tick_count++;
         CMD_READ: read_count++;
         CMD_WRITE: begin
            write_count++;
            // track the data mode so clock writes can be encoded sensibly
            if (idx == REG_B) binary_mode = ((data | fixed_now) & B_DATA_MODE) != 8'd0;
         end
         default: ;
      endcase
   endtask

   // stop offering and wait until every read has come back
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (reads_waiting != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_fixed_bits(input logic [7:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      fixed_now = value;
      setting_count++;
   endtask

   // clock field value in the encoding the current mode expects
   function automatic logic [7:0] encoded(input logic [7:0] v);
      logic [7:0] tens;
      tens = v / 8'd10;
      return binary_mode ? v : {tens[3:0], 4'(v % 8'd10)};
   endfunction

   // set the clock just short of a carry chain, tick across it and read back
   task automatic rollover_run();
      logic [7:0] mon;
      int         pick;
      if ($urandom_range(3) == 0) offer(CMD_WRITE, REG_B, 8'($urandom));
      pick = $urandom_range(99);
      if (pick < 85) mon = 8'($urandom_range(1, 12));
      else if (pick < 92) mon = 8'd0;
      else mon = 8'($urandom_range(13, 99));
      offer(CMD_WRITE, REG_SEC, encoded(8'($urandom_range(56, 59))));
      offer(CMD_WRITE, REG_MIN,
            encoded($urandom_range(3) == 0 ? 8'($urandom_range(59)) : 8'd59));
      offer(CMD_WRITE, REG_HOUR,
            encoded($urandom_range(3) == 0 ? 8'($urandom_range(23)) : 8'd23));
      offer(CMD_WRITE, REG_DOW, encoded(8'($urandom_range(1, 7))));
      offer(CMD_WRITE, REG_DOM, encoded(8'($urandom_range(26, 31))));
      offer(CMD_WRITE, REG_MON, encoded(mon));
      offer(CMD_WRITE, REG_YEAR,
            encoded($urandom_range(3) == 0 ? 8'd99 : 8'($urandom_range(99))));
      if ($urandom_range(3) == 0)
         offer(CMD_WRITE, $urandom_range(1) ? REG_SEC_ALARM : REG_HOUR_ALARM,
               8'($urandom));
      repeat ($urandom_range(2, 6)) begin
         if ($urandom_range(1)) offer(CMD_TICK, 4'($urandom), 8'($urandom));
         else offer(CMD_READ, 4'($urandom_range(12)), 8'($urandom));
      end
      for (int i = 0; i < CLOCK_COUNT; i++)
         if ($urandom_range(1)) offer(CMD_READ, 4'(i), 8'($urandom));
      offer(CMD_READ, REG_C, 8'($urandom));
   endtask

   task automatic noise_run();
      repeat (10) offer(2'($urandom), 4'($urandom), 8'($urandom));
   endtask

   task automatic random_phase(input int count);
      int stop_at;
      stop_at = item_count + count;
      while (item_count < stop_at) begin
         if ($urandom_range(9) < 7) rollover_run();
         else noise_run();
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_TICK;
      req_reg_index  = REG_SEC;
      req_write_data = 8'd0;
      csr_valid      = 1'b0;
      csr_data       = 8'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: reset values, flags, unchecked writes and odd registers
      offer(CMD_READ, REG_B, 8'h00);
      offer(CMD_READ, REG_DOM, 8'h00);
      offer(CMD_READ, REG_C, 8'h00);
      offer(CMD_TICK, REG_SEC, 8'h00);
      offer(CMD_READ, REG_C, 8'h00);
      offer(CMD_READ, REG_C, 8'h00);
      offer(CMD_WRITE, REG_C, 8'hFF);
      offer(CMD_READ, REG_C, 8'h00);
      offer(CMD_WRITE, REG_A, 8'hA5);
      offer(CMD_READ, REG_A, 8'h00);
      // non-bcd digits stored, then a large value read back in bcd
      offer(CMD_WRITE, REG_YEAR, 8'hFF);
      offer(CMD_READ, REG_YEAR, 8'h00);
      offer(CMD_WRITE, REG_B, 8'hFF);
      offer(CMD_READ, REG_B, 8'h00);
      // carry from an unchecked seconds value into the minutes, with the month set out of range
      offer(CMD_WRITE, REG_SEC, 8'hFE);
      offer(CMD_WRITE, REG_MIN_ALARM, 8'h00);
      offer(CMD_WRITE, REG_MON, 8'h00);
      offer(CMD_TICK, REG_SEC, 8'h00);
      offer(CMD_READ, REG_SEC, 8'h00);
      offer(CMD_WRITE, REG_D, 8'hFF);
      offer(CMD_READ, REG_D, 8'h00);
      offer(CMD_WRITE, REG_NVRAM, 8'hFF);
      offer(CMD_READ, REG_NVRAM, 8'h00);
      offer(CMD_UNUSED, REG_E, 8'h55);
      offer(CMD_READ, REG_E, 8'h00);

      // all fixed bits set, so b always lands in binary mode
      set_fixed_bits(8'hFF);
      offer(CMD_WRITE, REG_B, 8'h00);
      random_phase(PHASE_ITEMS);

      // no fixed bits, and a stretch with no idling on either side
      set_fixed_bits(8'h00);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      offer(CMD_WRITE, REG_B, 8'h00);
      random_phase(PHASE_ITEMS);
      sender_idles = 1'b1;
      receiver_idles = 1'b1;

      // random fixed bits, and a long hold-off that backs up the request side
      set_fixed_bits(8'($urandom));
      offer(CMD_WRITE, REG_B, 8'($urandom));
      hold_off = 1'b1;
      repeat (40) offer(CMD_READ, 4'($urandom_range(12)), 8'($urandom));
      random_phase(PHASE_ITEMS);

      // back to the reset value
      set_fixed_bits(B_FIXED_RESET);
      offer(CMD_WRITE, REG_B, 8'($urandom));
      random_phase(PHASE_ITEMS);

      settle();
      $display("covered %0d requests: %0d ticks, %0d reads, %0d writes",
               item_count, tick_count, read_count, write_count);
      $display("under %0d csr settings, with random stalls and one long read hold-off",
               setting_count);
      if (fail_count == 0 && reads_waiting == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
